// ===== sv/assert_macros.svh =====
// assertion helpers for the tracker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle consequence of a condition
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/satr_pkg.sv =====
package satr_pkg;

    localparam int SEQ_BITS    = 16;
    localparam int COUNT_BITS  = 16;
    localparam int TOTAL_BITS  = 32;
    localparam int RANGE_DEPTH = 16;
    localparam int PTR_W       = $clog2(RANGE_DEPTH);
    localparam int FILL_W      = $clog2(RANGE_DEPTH + 1);

    typedef logic [SEQ_BITS-1:0]   t_seq;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [TOTAL_BITS-1:0] t_total;
    typedef logic [PTR_W-1:0]      t_ptr;
    typedef logic [FILL_W-1:0]     t_fill;

    localparam t_count COUNT_MAX = '1;

    typedef enum logic {
        OP_RECEIVE = 1'b0,
        OP_SEND    = 1'b1
    } t_op;

    typedef struct packed {
        t_seq   start;
        t_count count;
    } t_range;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl_cmd;

    typedef struct packed {
        logic   accepted;
        t_seq   out_seq;
        logic   ack_valid;
        t_seq   ack_start;
        t_count ack_count;
        logic   ack_overflow;
        t_total sends_done;
    } t_result;

    function automatic t_ptr ptr_inc(input t_ptr p);
        t_ptr r;
        if (p == t_ptr'(RANGE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    function automatic t_ptr ptr_dec(input t_ptr p);
        t_ptr r;
        if (p == '0) begin
            r = t_ptr'(RANGE_DEPTH - 1);
        end else begin
            r = p - 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== sv/satr_if.sv =====
interface satr_item_if;
    import satr_pkg::*;
    logic valid;
    logic ready;
    logic operation;
    t_seq seq_in;

    modport source (output valid, output operation, output seq_in, input ready);
    modport sink   (input valid, input operation, input seq_in, output ready);
endinterface

interface satr_result_if;
    import satr_pkg::*;
    logic   valid;
    logic   ready;
    logic   accepted;
    t_seq   out_seq;
    logic   ack_valid;
    t_seq   ack_start;
    t_count ack_count;
    logic   ack_overflow;
    t_total sends_done;

    modport source (output valid, output accepted, output out_seq, output ack_valid,
                    output ack_start, output ack_count, output ack_overflow,
                    output sends_done, input ready);
    modport sink   (input valid, input accepted, input out_seq, input ack_valid,
                    input ack_start, input ack_count, input ack_overflow,
                    input sends_done, output ready);
endinterface

// ===== sv/satr_datapath.sv =====
module satr_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  satr_pkg::t_ctrl_cmd i_cmd,
    input  logic                i_operation,
    input  satr_pkg::t_seq      i_seq_in,
    output satr_pkg::t_result   o_result
);
    import satr_pkg::*;

    `include "assert_macros.svh"

    t_range  r_mem [RANGE_DEPTH];
    t_range  r_head_q;

    logic    r_op;
    t_seq    r_seq;
    t_seq    r_next_out, n_next_out;
    t_seq    r_next_exp, n_next_exp;
    t_total  r_total, n_total;
    t_ptr    r_head, n_head;
    t_ptr    r_tail, n_tail;
    t_fill   r_fill, n_fill;
    t_seq    r_new_start, n_new_start;
    t_count  r_new_count, n_new_count;
    t_result r_res, n_res;

    logic    w_rx;
    logic    w_fresh;
    logic    w_extend;
    logic    w_full;
    logic    w_has;
    t_ptr    w_newest;
    t_seq    w_follow;

    assign w_rx     = (t_op'(r_op) == OP_RECEIVE);
    assign w_fresh  = (r_seq >= r_next_exp);
    assign w_has    = (r_fill != '0);
    assign w_full   = (r_fill == t_fill'(RANGE_DEPTH));
    assign w_newest = ptr_dec(r_tail);
    assign w_follow = r_new_start + t_seq'(r_new_count);
    assign w_extend = w_has && (r_seq == w_follow) && (r_new_count != COUNT_MAX);

    always_comb begin
        n_next_out  = r_next_out;
        n_next_exp  = r_next_exp;
        n_total     = r_total;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_new_start = r_new_start;
        n_new_count = r_new_count;
        n_res       = r_res;
        if (i_cmd.exec) begin
            n_res = '0;
            if (w_rx) begin
                if (w_fresh) begin
                    n_res.accepted = 1'b1;
                    n_next_exp     = r_seq + 1'b1;
                    if (w_extend) begin
                        n_new_count = r_new_count + 1'b1;
                    end else if (w_full) begin
                        n_res.ack_overflow = 1'b1;
                    end else begin
                        n_new_start = r_seq;
                        n_new_count = t_count'(1);
                        n_tail      = ptr_inc(r_tail);
                        n_fill      = r_fill + 1'b1;
                    end
                end
            end else begin
                n_res.out_seq = r_next_out;
                n_next_out    = r_next_out + 1'b1;
                n_total       = r_total + 1'b1;
                if (w_has) begin
                    n_res.ack_valid = 1'b1;
                    n_res.ack_start = r_head_q.start;
                    n_res.ack_count = r_head_q.count;
                    n_head          = ptr_inc(r_head);
                    n_fill          = r_fill - 1'b1;
                end
            end
            n_res.sends_done = n_total;
        end
    end

    // range queue storage, head read registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_rx && w_fresh) begin
            if (w_extend) begin
                r_mem[w_newest] <= '{start: r_new_start, count: r_new_count + 1'b1};
            end else if (!w_full) begin
                r_mem[r_tail] <= '{start: r_seq, count: t_count'(1)};
            end
        end
        r_head_q <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_seq <= i_seq_in;
        end
        r_new_start <= n_new_start;
        r_new_count <= n_new_count;
        r_res       <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_out <= '0;
            r_next_exp <= '0;
            r_total    <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_fill     <= '0;
        end else begin
            r_next_out <= n_next_out;
            r_next_exp <= n_next_exp;
            r_total    <= n_total;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_fill     <= n_fill;
        end
    end

    assign o_result = r_res;

    `ASSERT_CLK(a_fill_bound, i_clk, i_rst_n, r_fill <= t_fill'(RANGE_DEPTH), "fill above depth")
    `ASSERT_NEXT(a_pop_fill, i_clk, i_rst_n, i_cmd.exec && !w_rx && w_has, r_fill == $past(r_fill) - 1'b1, "pop did not drain fill")
    `ASSERT_NEXT(a_overflow_full, i_clk, i_rst_n, i_cmd.exec && w_rx && w_fresh && !w_extend && w_full, r_res.ack_overflow && r_fill == t_fill'(RANGE_DEPTH), "overflow not flagged")

endmodule

// ===== sv/satr_controller.sv =====
module satr_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output satr_pkg::t_ctrl_cmd o_cmd
);
    import satr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec  = (r_state == S_EXEC);

endmodule

// ===== sv/sequence_ack_range_tracker_unit.sv =====
// Sequence and acknowledgement tracker for one side of a reliable datagram link.
// A receive beat (operation 0) checks seq_in against the next expected number and
// records an accepted number in a queue of pending ack ranges, or flags
// ack_overflow if it is full and the newest range cannot grow; a send beat
// (operation 1) stamps the next outgoing number and pops the oldest range. One
// item at a time is taken in the idle state, worked in the exec state, where the
// range queue's registered head read and its tail write are used, and shown, from
// a registered result, in the done state until taken. The queue memory needs no
// clearing after reset; fill tracking keeps unwritten entries from ever being read.
module sequence_ack_range_tracker_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    satr_item_if.sink            i_item,
    satr_result_if.source        o_result
);
    import satr_pkg::*;

    t_ctrl_cmd w_cmd;
    t_result   w_res;
    logic      w_in_ready;
    logic      w_out_valid;

    satr_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_result.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    satr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_operation (i_item.operation),
        .i_seq_in    (i_item.seq_in),
        .o_result    (w_res)
    );

    assign i_item.ready          = w_in_ready;
    assign o_result.valid        = w_out_valid;
    assign o_result.accepted     = w_res.accepted;
    assign o_result.out_seq      = w_res.out_seq;
    assign o_result.ack_valid    = w_res.ack_valid;
    assign o_result.ack_start    = w_res.ack_start;
    assign o_result.ack_count    = w_res.ack_count;
    assign o_result.ack_overflow = w_res.ack_overflow;
    assign o_result.sends_done   = w_res.sends_done;

endmodule
